// ----- hdl/rotate_image_nearest_defines.svh -----
// assertion macros for the rotate_image_nearest block
`ifndef ROTATE_IMAGE_NEAREST_DEFINES_SVH
`define ROTATE_IMAGE_NEAREST_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RIN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RIN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/rotimg_pkg.sv -----
// shared constants, types and helpers for the rotate_image_nearest block
package rotimg_pkg;

   localparam int MAX_WIDTH      = 256;
   localparam int MAX_HEIGHT     = 256;
   localparam int COEF_FRAC_BITS = 14;

   // fixed field and register widths
   localparam int COORD_BITS    = 8;
   localparam int PIXEL_BITS    = 32;
   localparam int CSR_SIZE_BITS = 9;
   localparam int COEF_BITS     = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;

   // derived widths
   localparam int MAX_DIM      = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_BITS     = $clog2(MAX_DIM + 1);
   localparam int DIFF_BITS    = ((DIM_BITS > COORD_BITS) ? DIM_BITS : COORD_BITS) + 1;
   localparam int PROD_BITS    = COEF_BITS + DIFF_BITS;
   localparam int ACC_BITS     = PROD_BITS + 1;
   localparam int POS_BITS     = ACC_BITS - COEF_FRAC_BITS + 1;
   localparam int ROW_IDX_BITS = $clog2(MAX_HEIGHT);
   localparam int COL_IDX_BITS = $clog2(MAX_WIDTH);
   localparam int ADDR_BITS    = ROW_IDX_BITS + COL_IDX_BITS;
   localparam int ROW_EXT_BITS = (ROW_IDX_BITS > COORD_BITS) ? ROW_IDX_BITS : COORD_BITS;
   localparam int COL_EXT_BITS = (COL_IDX_BITS > COORD_BITS) ? COL_IDX_BITS : COORD_BITS;

   // input function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COS_COEF     = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIN_COEF     = 2'd3;

   // per-cycle command to the shared multiply-accumulate unit
   typedef struct packed {
      logic enable;
      logic clear;
      logic negate;
   } mac_ctrl_type;

   // limit a size register to 1..maxv
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CSR_SIZE_BITS-1:0] v,
                                                     input int maxv);
      logic [DIM_BITS-1:0] res;
      if (v == '0) begin
         res = DIM_BITS'(1);
      end else if (int'(v) > maxv) begin
         res = DIM_BITS'(maxv);
      end else begin
         res = DIM_BITS'(v);
      end
      return res;
   endfunction

endpackage

// ----- hdl/rotimg_mac.sv -----
// shared signed multiply-accumulate unit for the rotation terms
module rotimg_mac (
   input  logic                                   clock,
   input  rotimg_pkg::mac_ctrl_type               ctrl,
   input  logic signed [rotimg_pkg::COEF_BITS-1:0] coef,
   input  logic signed [rotimg_pkg::DIFF_BITS-1:0] operand,
   output logic signed [rotimg_pkg::ACC_BITS-1:0]  acc
);

   logic signed [rotimg_pkg::PROD_BITS-1:0] prod;
   logic signed [rotimg_pkg::ACC_BITS-1:0]  term;
   logic signed [rotimg_pkg::ACC_BITS-1:0]  acc_ff;
   logic signed [rotimg_pkg::ACC_BITS-1:0]  acc_in;

   always_comb begin
      prod = coef * operand;
      term = ctrl.negate ? -rotimg_pkg::ACC_BITS'(prod) : rotimg_pkg::ACC_BITS'(prod);
      if (!ctrl.enable) begin
         acc_in = acc_ff;
      end else if (ctrl.clear) begin
         acc_in = term;
      end else begin
         acc_in = acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- hdl/rotimg_store.sv -----
// source pixel memory, one write port and one registered read port
module rotimg_store (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [rotimg_pkg::ADDR_BITS-1:0]     wr_addr,
   input  logic [rotimg_pkg::PIXEL_BITS-1:0]    wr_data,
   input  logic                                 rd_en,
   input  logic [rotimg_pkg::ADDR_BITS-1:0]     rd_addr,
   output logic [rotimg_pkg::PIXEL_BITS-1:0]    rd_data
);

   localparam int DEPTH = 2 ** rotimg_pkg::ADDR_BITS;

   logic [rotimg_pkg::PIXEL_BITS-1:0] mem [DEPTH];
   logic [rotimg_pkg::PIXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/rotate_image_nearest.sv -----
// top level: register file, query sequencer and result register of the rotation block
//
// A load word (func 0) writes one source pixel; it gives no result. A query word
// (func 1) runs through a sequence of states: size clamp and centre offsets, four
// passes through the single shared 16 x 10 bit multiply-accumulate unit (the two terms
// of the row position, then the two of the column position), the bounds test with the
// memory read, and the registered read data. busy is high through that sequence; the
// result word appears on rsp_pixel_out and rsp_inside_res with rsp_strobe high for
// exactly one cycle right after, and a new word may start in that same cycle. The
// receiver cannot stall, so the strobe cycle is the only chance to take the result.
// Queries outside the image or mapping outside the source return 0 with rsp_inside_res
// low. The pixel store has no reset; a query must only reach pixels that were loaded.
// Configuration must be written while busy is low; the block does not enforce it.
`include "rotate_image_nearest_defines.svh"

module rotate_image_nearest (
   input  logic                                      clock,
   input  logic                                      reset,
   // command word
   input  logic                                      start,
   output logic                                      busy,
   input  logic                                      req_func,
   input  logic [rotimg_pkg::COORD_BITS-1:0]         req_row,
   input  logic [rotimg_pkg::COORD_BITS-1:0]         req_col,
   input  logic [rotimg_pkg::PIXEL_BITS-1:0]         req_pixel_in,
   // result word
   output logic                                      rsp_strobe,
   output logic [rotimg_pkg::PIXEL_BITS-1:0]         rsp_pixel_out,
   output logic                                      rsp_inside_res,
   // register writes
   input  logic                                      csr_write_en,
   input  logic [rotimg_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [rotimg_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PREP  = 8'b0000_0010,
      ST_MAC0  = 8'b0000_0100,
      ST_MAC1  = 8'b0000_1000,
      ST_MAC2  = 8'b0001_0000,
      ST_MAC3  = 8'b0010_0000,
      ST_CHECK = 8'b0100_0000,
      ST_READ  = 8'b1000_0000
   } state_type;

   localparam int DB = rotimg_pkg::DIM_BITS;
   localparam int FB = rotimg_pkg::COEF_FRAC_BITS;
   localparam int PB = rotimg_pkg::POS_BITS;
   localparam int AB = rotimg_pkg::ACC_BITS;

   // configuration registers
   logic [rotimg_pkg::CSR_SIZE_BITS-1:0] image_width_ff;
   logic [rotimg_pkg::CSR_SIZE_BITS-1:0] image_height_ff;
   logic signed [rotimg_pkg::COEF_BITS-1:0] cos_coef_ff;
   logic signed [rotimg_pkg::COEF_BITS-1:0] sin_coef_ff;

   // sequencer state
   state_type state_ff, state_in;
   logic [rotimg_pkg::COORD_BITS-1:0] row_ff, col_ff;
   logic [DB-1:0] width_ff, height_ff, width_in, height_in;
   logic [DB-2:0] cx_ff, cy_ff;
   logic signed [rotimg_pkg::DIFF_BITS-1:0] di_ff, dj_ff, di_in, dj_in;
   logic outside_ff, outside_in;
   logic signed [PB-1:0] x_ff, x_pos, y_pos;
   logic inside_ff, inside_in;

   // result register
   logic rsp_strobe_ff;
   logic [rotimg_pkg::PIXEL_BITS-1:0] rsp_pixel_ff;
   logic rsp_inside_ff;

   // shared unit
   rotimg_pkg::mac_ctrl_type mac_ctrl;
   logic signed [rotimg_pkg::COEF_BITS-1:0] mac_coef;
   logic signed [rotimg_pkg::DIFF_BITS-1:0] mac_operand;
   logic signed [AB-1:0] mac_acc;
   logic signed [AB-FB-1:0] acc_floor;

   // store ports
   logic accept;
   logic load_en;
   logic [rotimg_pkg::ROW_EXT_BITS-1:0] ld_row;
   logic [rotimg_pkg::COL_EXT_BITS-1:0] ld_col;
   logic [rotimg_pkg::ADDR_BITS-1:0] wr_addr, rd_addr;
   logic rd_en;
   logic [rotimg_pkg::PIXEL_BITS-1:0] rd_data;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= rotimg_pkg::CSR_SIZE_BITS'(256);
         image_height_ff <= rotimg_pkg::CSR_SIZE_BITS'(256);
         cos_coef_ff     <= rotimg_pkg::COEF_BITS'(16384);
         sin_coef_ff     <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            rotimg_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[rotimg_pkg::CSR_SIZE_BITS-1:0];
            end
            rotimg_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[rotimg_pkg::CSR_SIZE_BITS-1:0];
            end
            rotimg_pkg::CSR_COS_COEF: begin
               cos_coef_ff <= csr_wdata;
            end
            rotimg_pkg::CSR_SIN_COEF: begin
               sin_coef_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // load path straight into the store
   always_comb begin
      ld_row  = rotimg_pkg::ROW_EXT_BITS'(req_row);
      ld_col  = rotimg_pkg::COL_EXT_BITS'(req_col);
      load_en = accept && (req_func == rotimg_pkg::FUNC_LOAD)
                && (int'(ld_row) < rotimg_pkg::MAX_HEIGHT)
                && (int'(ld_col) < rotimg_pkg::MAX_WIDTH);
      wr_addr = {ld_row[rotimg_pkg::ROW_IDX_BITS-1:0], ld_col[rotimg_pkg::COL_IDX_BITS-1:0]};
   end

   // clamp, centre offsets and query-outside test
   always_comb begin
      width_in   = rotimg_pkg::clamp_dim(image_width_ff, rotimg_pkg::MAX_WIDTH);
      height_in  = rotimg_pkg::clamp_dim(image_height_ff, rotimg_pkg::MAX_HEIGHT);
      di_in      = signed'(rotimg_pkg::DIFF_BITS'(row_ff))
                   - signed'(rotimg_pkg::DIFF_BITS'(height_in[DB-1:1]));
      dj_in      = signed'(rotimg_pkg::DIFF_BITS'(col_ff))
                   - signed'(rotimg_pkg::DIFF_BITS'(width_in[DB-1:1]));
      outside_in = (DB'(row_ff) >= height_in) || (DB'(col_ff) >= width_in);
   end

   // floor by arithmetic shift, then add the centre back
   always_comb begin
      acc_floor = mac_acc[AB-1:FB];
      x_pos     = PB'(acc_floor) + signed'(PB'(cx_ff));
      y_pos     = PB'(acc_floor) + signed'(PB'(cy_ff));
      inside_in = !outside_ff
                  && (x_ff > 0) && (x_ff < signed'(PB'(height_ff)))
                  && (y_pos > 0) && (y_pos < signed'(PB'(width_ff)));
      rd_addr   = {x_ff[rotimg_pkg::ROW_IDX_BITS-1:0], y_pos[rotimg_pkg::COL_IDX_BITS-1:0]};
      rd_en     = (state_ff == ST_CHECK) && inside_in;
   end

   // sequencer and operand select for the shared unit
   always_comb begin
      state_in    = state_ff;
      mac_ctrl    = '0;
      mac_coef    = cos_coef_ff;
      mac_operand = di_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == rotimg_pkg::FUNC_QUERY)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_MAC0;
         end
         ST_MAC0: begin
            mac_ctrl = '{enable: 1'b1, clear: 1'b1, negate: 1'b0};
            state_in = ST_MAC1;
         end
         ST_MAC1: begin
            mac_ctrl    = '{enable: 1'b1, clear: 1'b0, negate: 1'b1};
            mac_coef    = sin_coef_ff;
            mac_operand = dj_ff;
            state_in    = ST_MAC2;
         end
         ST_MAC2: begin
            mac_ctrl    = '{enable: 1'b1, clear: 1'b1, negate: 1'b0};
            mac_operand = dj_ff;
            state_in    = ST_MAC3;
         end
         ST_MAC3: begin
            mac_ctrl = '{enable: 1'b1, clear: 1'b0, negate: 1'b0};
            mac_coef = sin_coef_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (state_ff == ST_PREP) begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         cx_ff      <= height_in[DB-1:1];
         cy_ff      <= width_in[DB-1:1];
         di_ff      <= di_in;
         dj_ff      <= dj_in;
         outside_ff <= outside_in;
      end
      // row position is complete in the accumulator in the cycle after its second term
      if (state_ff == ST_MAC2) begin
         x_ff <= x_pos;
      end
      if (state_ff == ST_CHECK) begin
         inside_ff <= inside_in;
      end
      if (state_ff == ST_READ) begin
         rsp_pixel_ff  <= inside_ff ? rd_data : '0;
         rsp_inside_ff <= inside_ff;
      end
   end

   rotimg_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .coef    (mac_coef),
      .operand (mac_operand),
      .acc     (mac_acc)
   );

   rotimg_store u_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_inside_res = rsp_inside_ff;

   `RIN_ASSERT_NEXT(a_query_goes_busy, accept && (req_func == rotimg_pkg::FUNC_QUERY), busy, "query word did not start the sequence")
   `RIN_ASSERT_NEXT(a_load_stays_idle, accept && (req_func == rotimg_pkg::FUNC_LOAD), !busy && !rsp_strobe, "load word started a sequence or a result")
   `RIN_ASSERT_NOW(a_strobe_after_read, rsp_strobe, $past(state_ff == ST_READ) && !busy, "result strobe outside the end of a query")
   `RIN_ASSERT_NOW(a_black_fill, rsp_strobe && !rsp_inside_res, rsp_pixel_out == '0, "outside result word is not black")

endmodule

// ----- dv/rotate_image_nearest_tb.sv -----
// self-checking testbench for the nearest-neighbor image rotation block
`timescale 1ns / 100ps

module rotate_image_nearest_tb;

   typedef struct {
      logic [rotimg_pkg::PIXEL_BITS-1:0] pixel;
      logic                              taken;
   } rotated_pixel_type;

   // mirror of the pixel store and registers; predicts each query word
   class rotated_pixel_board;
      logic [rotimg_pkg::PIXEL_BITS-1:0] source_pixels [rotimg_pkg::MAX_WIDTH*rotimg_pkg::MAX_HEIGHT];
      bit loaded [rotimg_pkg::MAX_WIDTH*rotimg_pkg::MAX_HEIGHT];
      logic [rotimg_pkg::CSR_SIZE_BITS-1:0]    width_reg = 9'd256;
      logic [rotimg_pkg::CSR_SIZE_BITS-1:0]    height_reg = 9'd256;
      logic signed [rotimg_pkg::COEF_BITS-1:0] cos_reg = 16'sd16384;
      logic signed [rotimg_pkg::COEF_BITS-1:0] sin_reg = '0;
      rotated_pixel_type                       pending_pixels [$];
      int                                      errors = 0;

      task flag_mismatch(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function int used_width();
         if (width_reg == 0) return 1;
         if (width_reg > rotimg_pkg::MAX_WIDTH) return rotimg_pkg::MAX_WIDTH;
         return int'(width_reg);
      endfunction

      function int used_height();
         if (height_reg == 0) return 1;
         if (height_reg > rotimg_pkg::MAX_HEIGHT) return rotimg_pkg::MAX_HEIGHT;
         return int'(height_reg);
      endfunction

      function void set_register(input logic [rotimg_pkg::CSR_IDX_BITS-1:0] idx,
                                 input logic [rotimg_pkg::CSR_DATA_BITS-1:0] data);
         case (idx)
            rotimg_pkg::CSR_IMAGE_WIDTH: begin
               width_reg = data[rotimg_pkg::CSR_SIZE_BITS-1:0];
            end
            rotimg_pkg::CSR_IMAGE_HEIGHT: begin
               height_reg = data[rotimg_pkg::CSR_SIZE_BITS-1:0];
            end
            rotimg_pkg::CSR_COS_COEF: begin
               cos_reg = data;
            end
            rotimg_pkg::CSR_SIN_COEF: begin
               sin_reg = data;
            end
         endcase
      endfunction

      // inverse rotation about the center; 1 when the source pixel is taken
      function bit source_pos(input logic [rotimg_pkg::COORD_BITS-1:0] row, col,
                              output int addr);
         longint h, w, di, dj, x, y;
         h = used_height();
         w = used_width();
         addr = 0;
         if (longint'(row) >= h || longint'(col) >= w) return 1'b0;
         di = longint'(row) - h / 2;
         dj = longint'(col) - w / 2;
         // arithmetic shift floors toward minus infinity
         x = ((longint'(cos_reg) * di - longint'(sin_reg) * dj)
              >>> rotimg_pkg::COEF_FRAC_BITS) + h / 2;
         y = ((longint'(cos_reg) * dj + longint'(sin_reg) * di)
              >>> rotimg_pkg::COEF_FRAC_BITS) + w / 2;
         if (x <= 0 || x >= h || y <= 0 || y >= w) return 1'b0;
         addr = int'(x) * rotimg_pkg::MAX_WIDTH + int'(y);
         return 1'b1;
      endfunction

      function void take_word(input logic func, input logic [rotimg_pkg::COORD_BITS-1:0] row, col,
                              input logic [rotimg_pkg::PIXEL_BITS-1:0] pix);
         rotated_pixel_type want;
         int addr;
         if (func == rotimg_pkg::FUNC_LOAD) begin
            addr = int'(row) * rotimg_pkg::MAX_WIDTH + int'(col);
            source_pixels[addr] = pix;
            loaded[addr] = 1'b1;
         end else begin
            want.taken = source_pos(row, col, addr);
            want.pixel = want.taken ? source_pixels[addr] : '0;
            pending_pixels.push_back(want);
         end
      endfunction

      task compare_pixel(input logic [rotimg_pkg::PIXEL_BITS-1:0] pix, input logic taken);
         rotated_pixel_type want;
         if (pending_pixels.size() == 0) begin
            flag_mismatch($sformatf("result word %h with no query pending", pix));
         end else begin
            want = pending_pixels.pop_front();
            if (pix !== want.pixel)
               flag_mismatch($sformatf("pixel_out %h, want %h", pix, want.pixel));
            if (taken !== want.taken)
               flag_mismatch($sformatf("inside_res %b, want %b", taken, want.taken));
         end
      endtask
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic                                 req_func = rotimg_pkg::FUNC_LOAD;
   logic [rotimg_pkg::COORD_BITS-1:0]    req_row = '0;
   logic [rotimg_pkg::COORD_BITS-1:0]    req_col = '0;
   logic [rotimg_pkg::PIXEL_BITS-1:0]    req_pixel_in = '0;
   logic                                 rsp_strobe;
   logic [rotimg_pkg::PIXEL_BITS-1:0]    rsp_pixel_out;
   logic                                 rsp_inside_res;
   logic                                 csr_write_en = 1'b0;
   logic [rotimg_pkg::CSR_IDX_BITS-1:0]  csr_index = rotimg_pkg::CSR_IMAGE_WIDTH;
   logic [rotimg_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   rotated_pixel_board sb = new();
   int sender_idle_pct = 0;
   int items_sent = 0;

   rotate_image_nearest dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_pixel_in   (req_pixel_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_inside_res (rsp_inside_res),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   // result words are only valid in the strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.compare_pixel(rsp_pixel_out, rsp_inside_res);
   end

   // leaves start high so back-to-back words need no extra assignment
   task automatic send_word(input logic func, input logic [rotimg_pkg::COORD_BITS-1:0] row, col,
                            input logic [rotimg_pkg::PIXEL_BITS-1:0] pix);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_row <= row;
      req_col <= col;
      req_pixel_in <= pix;
      do @(posedge clock); while (busy);
      sb.take_word(func, row, col, pix);
      items_sent++;
   endtask

   task automatic send_query(input logic [rotimg_pkg::COORD_BITS-1:0] row, col);
      int addr;
      // never let a query read an entry that was not loaded
      if (sb.source_pos(row, col, addr) && !sb.loaded[addr])
         send_word(rotimg_pkg::FUNC_LOAD, 8'(addr / rotimg_pkg::MAX_WIDTH),
                   8'(addr % rotimg_pkg::MAX_WIDTH), $urandom());
      send_word(rotimg_pkg::FUNC_QUERY, row, col, $urandom());
   endtask

   task automatic drain_results();
      int waited;
      start <= 1'b0;
      waited = 0;
      while (sb.pending_pixels.size() != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic configure(input logic [rotimg_pkg::CSR_DATA_BITS-1:0] wval, hval, cval, sval);
      logic [rotimg_pkg::CSR_IDX_BITS-1:0]  regs [4];
      logic [rotimg_pkg::CSR_DATA_BITS-1:0] vals [4];
      regs = '{rotimg_pkg::CSR_IMAGE_WIDTH, rotimg_pkg::CSR_IMAGE_HEIGHT,
               rotimg_pkg::CSR_COS_COEF, rotimg_pkg::CSR_SIN_COEF};
      vals = '{wval, hval, cval, sval};
      for (int i = 0; i < 4; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_register(regs[i], vals[i]);
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [rotimg_pkg::CSR_DATA_BITS-1:0] random_size();
      logic [rotimg_pkg::CSR_DATA_BITS-1:0] v;
      case ($urandom_range(0, 9)) inside
         [0:5]: begin
            v = rotimg_pkg::CSR_DATA_BITS'($urandom_range(2, 20));
         end
         [6:7]: begin
            v = 16'd256;
         end
         8: begin
            v = rotimg_pkg::CSR_DATA_BITS'($urandom_range(0, 511));
         end
         default: begin
            v = rotimg_pkg::CSR_DATA_BITS'($urandom_range(21, 255));
         end
      endcase
      // bits above the register width are dropped by the block
      if ($urandom_range(0, 3) == 0) v[15:9] = 7'($urandom());
      return v;
   endfunction

   initial begin
      real                                  ang;
      logic [rotimg_pkg::CSR_DATA_BITS-1:0] cval, sval;
      logic [rotimg_pkg::COORD_BITS-1:0]    r, c;
      int                                   h, w;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 13;
      send_word(rotimg_pkg::FUNC_LOAD, 8'd0, 8'd0, 32'h0000_0000);
      send_word(rotimg_pkg::FUNC_LOAD, 8'd255, 8'd255, 32'hFFFF_FFFF);
      send_word(rotimg_pkg::FUNC_LOAD, 8'd0, 8'd255, 32'hAAAA_AAAA);
      send_word(rotimg_pkg::FUNC_LOAD, 8'd255, 8'd0, 32'h5555_5555);
      send_word(rotimg_pkg::FUNC_LOAD, 8'd1, 8'd1, 32'h1234_5678);
      // identity at reset: row 0 and column 0 of the source are never taken
      send_query(8'd0, 8'd0);
      send_query(8'd255, 8'd255);
      send_query(8'd0, 8'd255);
      send_query(8'd255, 8'd0);
      send_query(8'd1, 8'd1);
      send_query(8'd128, 8'd128);
      drain_results();

      // width 0 clamps to 1, height 511 to 256, coefficients at both rails
      configure(16'h0000, 16'h01FF, 16'h7FFF, 16'h8000);
      send_query(8'd255, 8'd0);
      send_query(8'd0, 8'd0);
      send_query(8'd10, 8'd200);
      send_query(8'd128, 8'd0);
      drain_results();

      // single row, cos -1.0 and sin +1.0
      configure(16'd256, 16'd1, 16'hC000, 16'h4000);
      send_query(8'd0, 8'd0);
      send_query(8'd0, 8'd255);
      send_query(8'd1, 8'd128);
      drain_results();

      // zero coefficients collapse every in-image query onto the center
      configure(16'd2, 16'd2, 16'h0000, 16'h0000);
      send_query(8'd0, 8'd1);
      send_query(8'd1, 8'd0);
      send_query(8'd1, 8'd1);
      send_query(8'd2, 8'd0);

      for (int ph = 0; ph < 9; ph++) begin
         sender_idle_pct = (ph < 3) ? 13 : (ph < 6) ? 78 : 0;
         drain_results();
         if ($urandom_range(0, 4) == 0) begin
            cval = rotimg_pkg::CSR_DATA_BITS'($urandom());
            sval = rotimg_pkg::CSR_DATA_BITS'($urandom());
         end else begin
            ang = $urandom_range(0, 359) * 3.141592653589793 / 180.0;
            cval = rotimg_pkg::CSR_DATA_BITS'($rtoi($floor($cos(ang) * 16384.0 + 0.5)));
            sval = rotimg_pkg::CSR_DATA_BITS'($rtoi($floor($sin(ang) * 16384.0 + 0.5)));
         end
         configure(random_size(), random_size(), cval, sval);
         while (items_sent < 30 + (ph + 1) * 58) begin
            h = sb.used_height();
            w = sb.used_width();
            if ($urandom_range(0, 4) == 0) begin
               r = rotimg_pkg::COORD_BITS'($urandom());
               c = rotimg_pkg::COORD_BITS'($urandom());
            end else begin
               r = rotimg_pkg::COORD_BITS'($urandom_range(0, h - 1));
               c = rotimg_pkg::COORD_BITS'($urandom_range(0, w - 1));
            end
            if ($urandom_range(0, 99) < 40)
               send_word(rotimg_pkg::FUNC_LOAD, r, c, $urandom());
            else
               send_query(r, c);
         end
      end

      drain_results();
      if (sb.pending_pixels.size() != 0)
         sb.flag_mismatch($sformatf("%0d queries never answered", sb.pending_pixels.size()));
      if (sb.errors == 0)
         $display("rotate_image_nearest_tb passed");
      else
         $display("rotate_image_nearest_tb failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("rotate_image_nearest_tb failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rotimg_pkg.sv
hdl/rotimg_mac.sv
hdl/rotimg_store.sv
hdl/rotate_image_nearest.sv
dv/rotate_image_nearest_tb.sv
